// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

   localparam int unsigned MAX_UNITS_DEFAULT = 128;
   localparam logic [8:0]  CAPACITY_RESET    = 9'd128;

   typedef enum logic [1:0] {
      STATUS_UNIT = 2'd0,
      STATUS_OK   = 2'd1,
      STATUS_FAIL = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] code_unit;
      status_type  status;
      logic [7:0]  unit_count;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [8:0] capacity_bytes;
   } csr_payload_type;

   // result of one decode step, handed from the decoder to the result register
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage

// ===== rtl/u8u16_chan.sv =====
interface u8u16_chan #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/utf8_to_utf16le_stream_unit.sv =====
// Decodes a zero-terminated UTF-8 string, one byte per item on req_if, into
// 16-bit code units on rsp_if (1 to 3 byte sequences, Basic Multilingual Plane
// only). A byte is taken every cycle while the result side keeps up; an accepted
// byte is held in the input register, and its result is presented from the
// result register once the decoder steps on that byte. req_if.ready falls only
// when both registers hold items and the result is not being taken. Bytes that
// finish no code point give no result; the zero byte always gives one final
// item with status and unit count and clears the decoder. After an error the
// string is failed and bytes up to the terminator give nothing. csr_if is
// always ready; write capacity_bytes only while no byte is in flight. A write
// does not clear a string in progress.
module utf8_to_utf16le_stream_unit #(
   parameter int unsigned MAX_UNITS = u8u16_pkg::MAX_UNITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   u8u16_chan.sink   req_if,
   u8u16_chan.sink   csr_if,
   u8u16_chan.source rsp_if
);
   import u8u16_pkg::*;

   logic       req_valid_ff;
   logic [7:0] req_byte_ff;
   logic [8:0] capacity_ff;
   logic       can_load;
   logic       step;
   result_type result;

   assign req_if.ready = !req_valid_ff || can_load;
   assign csr_if.ready = 1'b1;
   assign step         = req_valid_ff && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         req_byte_ff <= req_if.data.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_if.valid) begin
         capacity_ff <= csr_if.data.capacity_bytes;
      end
   end

   u8u16_core #(
      .MAX_UNITS (MAX_UNITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .in_byte        (req_byte_ff),
      .capacity_bytes (capacity_ff),
      .result         (result)
   );

   u8u16_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_if.data)
   );

`ifndef NO_ASSERTIONS
   a_final_has_status: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.last |->
         (rsp_if.data.status == STATUS_OK || rsp_if.data.status == STATUS_FAIL))
      else $error("final item carries a unit status");

   a_final_unit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.last |-> rsp_if.data.code_unit == 16'd0)
      else $error("final item carries a non-zero code unit");

   a_unit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.data.last |->
         rsp_if.data.status == STATUS_UNIT && rsp_if.data.unit_count != 8'd0)
      else $error("code unit item with bad status or zero count");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_if.valid |-> req_if.ready)
      else $error("input stalled with empty result register");
`endif

endmodule

// ===== rtl/u8u16_core.sv =====
module u8u16_core #(
   parameter int unsigned MAX_UNITS = u8u16_pkg::MAX_UNITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   input  logic [8:0]             capacity_bytes,
   output u8u16_pkg::result_type  result
);
   import u8u16_pkg::*;

   // the 9-bit capacity register cannot give more than 255 units
   localparam int unsigned CAP_UNITS = (MAX_UNITS > 255) ? 255 : MAX_UNITS;
   localparam logic [7:0]  CAP_LIMIT = CAP_UNITS[7:0];

   logic [1:0]  pending_ff, pending_in;
   logic [15:0] point_ff, point_in;
   logic [7:0]  units_ff, units_in;
   logic        failed_ff, failed_in;

   logic [7:0]  unit_limit;
   logic        done;
   logic        ok;

   assign unit_limit = (capacity_bytes[8:1] > CAP_LIMIT) ? CAP_LIMIT : capacity_bytes[8:1];

   always_comb begin
      pending_in = pending_ff;
      point_in   = point_ff;
      units_in   = units_ff;
      failed_in  = failed_ff;
      done       = 1'b0;
      ok         = 1'b0;
      result     = '0;

      if (in_byte == 8'd0) begin
         ok = !failed_ff && (pending_ff == 2'd0) && (capacity_bytes != 9'd0);
         result.valid              = 1'b1;
         result.payload.code_unit  = 16'd0;
         result.payload.status     = ok ? STATUS_OK : STATUS_FAIL;
         result.payload.unit_count = units_ff;
         result.payload.last       = 1'b1;
         pending_in = 2'd0;
         point_in   = 16'd0;
         units_in   = 8'd0;
         failed_in  = 1'b0;
      end else if (!failed_ff) begin
         if (pending_ff != 2'd0) begin
            if (in_byte[7:6] != 2'b10) begin
               failed_in = 1'b1;
            end else begin
               point_in   = {point_ff[9:0], in_byte[5:0]};
               pending_in = pending_ff - 2'd1;
               done       = (pending_ff == 2'd1);
            end
         end else if (!in_byte[7]) begin
            point_in = {8'd0, in_byte};
            done     = 1'b1;
         end else if (in_byte[7:5] == 3'b110) begin
            point_in   = {11'd0, in_byte[4:0]};
            pending_in = 2'd1;
         end else if (in_byte[7:4] == 4'b1110) begin
            point_in   = {12'd0, in_byte[3:0]};
            pending_in = 2'd2;
         end else begin
            failed_in = 1'b1;
         end

         if (done) begin
            if (units_ff >= unit_limit) begin
               failed_in = 1'b1;
            end else begin
               units_in                  = units_ff + 8'd1;
               result.valid              = 1'b1;
               result.payload.code_unit  = point_in;
               result.payload.status     = STATUS_UNIT;
               result.payload.unit_count = units_ff + 8'd1;
               result.payload.last       = 1'b0;
            end
            point_in = 16'd0;
         end
      end

      // drop the result when no byte steps this cycle
      if (!step) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         point_ff   <= 16'd0;
         units_ff   <= 8'd0;
         failed_ff  <= 1'b0;
      end else if (step) begin
         pending_ff <= pending_in;
         point_ff   <= point_in;
         units_ff   <= units_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

// ===== rtl/u8u16_rsp_reg.sv =====
module u8u16_rsp_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  u8u16_pkg::result_type      result,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output u8u16_pkg::rsp_payload_type rsp_data
);
   import u8u16_pkg::*;

   logic            valid_ff;
   rsp_payload_type data_ff;

   // free when empty or when the held item leaves this cycle
   assign can_load  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && result.valid) begin
         data_ff <= result.payload;
      end
   end

endmodule

// ===== test/tb_utf8_to_utf16le_stream_unit.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_utf16le_stream_unit;
   import u8u16_pkg::*;

   localparam int unsigned UNIT_CAP   = MAX_UNITS_DEFAULT;
   localparam int          IDLE_LIMIT = 2000;
   localparam int          PHASES     = 9;

   typedef struct packed {
      logic [7:0]      in_byte;
      bit              typed;
      rsp_payload_type res;
   } stim_row_type;

   typedef enum int {
      FLAW_STRAY_CONT,
      FLAW_FOUR_BYTE_LEAD,
      FLAW_BAD_CONT,
      FLAW_TRUNCATED
   } flaw_type;

   logic clock = 1'b0;
   logic reset;

   u8u16_chan #(.payload_type(req_payload_type)) req_ch ();
   u8u16_chan #(.payload_type(csr_payload_type)) csr_ch ();
   u8u16_chan #(.payload_type(rsp_payload_type)) rsp_ch ();

   utf8_to_utf16le_stream_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .csr_if (csr_ch),
      .rsp_if (rsp_ch)
   );

   always #5ns clock = ~clock;

   wire req_fire = req_ch.valid && req_ch.ready;
   wire csr_fire = csr_ch.valid && csr_ch.ready;
   wire rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // decoder state as the block should hold it
   logic [8:0]  cap_bytes     = CAPACITY_RESET;
   logic [1:0]  cont_left     = '0;
   logic [15:0] point_acc     = '0;
   logic [7:0]  units_done    = '0;
   bit          string_failed = 1'b0;

   rsp_payload_type decoded_q [$];

   bit calm = 1'b0;
   int mismatches   = 0;
   int bytes_sent   = 0;
   int live_bytes   = 0;
   int units_seen   = 0;
   int strings_seen = 0;
   int idle_cycles  = 0;

   stim_row_type directed_rows [28] = '{
      '{8'h00, 1'b1, '{16'h0000, STATUS_OK,   8'd0, 1'b1}},
      '{8'h7F, 1'b1, '{16'h007F, STATUS_UNIT, 8'd1, 1'b0}},
      '{8'h01, 1'b1, '{16'h0001, STATUS_UNIT, 8'd2, 1'b0}},
      '{8'hC2, 1'b0, '0},
      '{8'hA9, 1'b0, '0},
      '{8'hEF, 1'b0, '0},
      '{8'hBF, 1'b0, '0},
      '{8'hBF, 1'b1, '{16'hFFFF, STATUS_UNIT, 8'd4, 1'b0}},
      '{8'hE0, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'hC0, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'hED, 1'b0, '0},
      '{8'hA0, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'h00, 1'b1, '{16'h0000, STATUS_OK,   8'd7, 1'b1}},
      '{8'h80, 1'b0, '0},
      '{8'h41, 1'b0, '0},
      '{8'h00, 1'b1, '{16'h0000, STATUS_FAIL, 8'd0, 1'b1}},
      '{8'hF0, 1'b0, '0},
      '{8'h00, 1'b1, '{16'h0000, STATUS_FAIL, 8'd0, 1'b1}},
      '{8'hC3, 1'b0, '0},
      '{8'h41, 1'b0, '0},
      '{8'h00, 1'b1, '{16'h0000, STATUS_FAIL, 8'd0, 1'b1}},
      '{8'hE2, 1'b0, '0},
      '{8'h82, 1'b0, '0},
      '{8'h00, 1'b1, '{16'h0000, STATUS_FAIL, 8'd0, 1'b1}}
   };

   logic [8:0] phase_caps [PHASES] = '{
      9'd4, 9'd0, 9'd256, 9'd1, 9'd2, 9'd255, 9'd6, 9'd128, 9'd20
   };

   function automatic int unit_limit(input logic [8:0] cap);
      return (int'(cap >> 1) > UNIT_CAP) ? UNIT_CAP : int'(cap >> 1);
   endfunction

   // advance the decoder by one byte; returns 1 when the byte yields a result
   function automatic bit decode_byte(input logic [7:0] b, output rsp_payload_type r);
      bit complete;
      r = '0;
      complete = 1'b0;
      if (b == 8'h00) begin
         r.status     = (!string_failed && cont_left == 0 && cap_bytes != 0) ?
                        STATUS_OK : STATUS_FAIL;
         r.unit_count = units_done;
         r.last       = 1'b1;
         cont_left     = '0;
         point_acc     = '0;
         units_done    = '0;
         string_failed = 1'b0;
         return 1'b1;
      end
      if (string_failed)
         return 1'b0;
      if (cont_left != 0) begin
         if (b[7:6] != 2'b10) begin
            string_failed = 1'b1;
            return 1'b0;
         end
         point_acc = {point_acc[9:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         complete  = (cont_left == 0);
      end else if (!b[7]) begin
         point_acc = {8'h00, b};
         complete  = 1'b1;
      end else if (b[7:5] == 3'b110) begin
         point_acc = {11'd0, b[4:0]};
         cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         point_acc = {12'd0, b[3:0]};
         cont_left = 2'd2;
      end else begin
         string_failed = 1'b1;
         return 1'b0;
      end
      if (!complete)
         return 1'b0;
      // overflow: drop the code point and fail the string
      if (int'(units_done) + 1 > unit_limit(cap_bytes)) begin
         string_failed = 1'b1;
         point_acc     = '0;
         return 1'b0;
      end
      units_done   = units_done + 8'd1;
      r.code_unit  = point_acc;
      r.status     = STATUS_UNIT;
      r.unit_count = units_done;
      r.last       = 1'b0;
      point_acc    = '0;
      return 1'b1;
   endfunction

   function automatic int idle_span();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input rsp_payload_type typed_res = '0);
      int gap;
      rsp_payload_type res;
      gap = idle_span();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data.in_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      if (!string_failed)
         live_bytes++;
      if (decode_byte(b, res))
         decoded_q.push_back(typed ? typed_res : res);
   endtask

   task automatic send_char();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         send_byte(8'($urandom_range(1, 127)));
      end else if (kind < 7) begin
         send_byte(8'($urandom_range(8'hC0, 8'hDF)));
         send_byte(cont_byte());
      end else begin
         send_byte(8'($urandom_range(8'hE0, 8'hEF)));
         send_byte(cont_byte());
         send_byte(cont_byte());
      end
   endtask

   task automatic send_string(input int n_chars, input bit noisy);
      int flaw_at;
      flaw_type flaw;
      logic [7:0] lead;
      flaw_at = noisy ? $urandom_range(0, n_chars) : -1;
      calm = ($urandom_range(0, 5) == 0);
      for (int i = 0; i <= n_chars; i++) begin
         if (i == flaw_at) begin
            flaw = flaw_type'($urandom_range(0, 3));
            lead = 8'($urandom_range(8'hC0, 8'hEF));
            case (flaw)
               FLAW_STRAY_CONT:     send_byte(8'($urandom_range(8'h80, 8'hBF)));
               FLAW_FOUR_BYTE_LEAD: send_byte(8'($urandom_range(8'hF0, 8'hFF)));
               FLAW_BAD_CONT: begin
                  send_byte(lead);
                  send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h01, 8'h7F)) :
                                                   8'($urandom_range(8'hC0, 8'hFF)));
               end
               FLAW_TRUNCATED: begin
                  // end the string with the sequence still open
                  send_byte(lead);
                  if (lead >= 8'hE0 && $urandom_range(0, 1))
                     send_byte(cont_byte());
                  break;
               end
            endcase
         end
         if (i < n_chars)
            send_char();
      end
      send_byte(8'h00);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      // let ignored bytes drain through the pipeline
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [8:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= csr_payload_type'(v);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      cap_bytes = v;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_fire) begin
         if (rsp_ch.data.last === 1'b1)
            strings_seen++;
         else
            units_seen++;
         if (decoded_q.size() == 0) begin
            $display("%0t ns: unexpected item, expected none, got %h",
                     $time, rsp_ch.data);
            mismatches++;
         end else begin
            want = decoded_q.pop_front();
            check_field("code_unit",  want.code_unit, rsp_ch.data.code_unit);
            check_field("status",     16'(want.status), 16'(rsp_ch.data.status));
            check_field("unit_count", 16'(want.unit_count), 16'(rsp_ch.data.unit_count));
            check_field("last",       16'(want.last), 16'(rsp_ch.data.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire || csr_fire)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d items outstanding",
                  $time, IDLE_LIMIT, decoded_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: random stalls
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
            hold = idle_span();
         end
      end
   end

   initial begin
      int phase_end;
      int n;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].in_byte, directed_rows[i].typed, directed_rows[i].res);

      for (int p = 0; p <= PHASES; p++) begin
         settle();
         write_capacity(p < PHASES ? phase_caps[p] : 9'($urandom_range(0, 256)));
         phase_end = bytes_sent + 120;
         // open each setting with a string two past the limit to force overflow
         send_string(unit_limit(cap_bytes) + 2, 1'b0);
         while (bytes_sent < phase_end) begin
            if ($urandom_range(0, 19) == 0) begin
               n = $urandom_range(1, 12);
               repeat (n) send_byte(8'($urandom_range(1, 255)));
               send_byte(8'h00);
            end else begin
               n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
                                                  $urandom_range(0, 10);
               send_string(n, $urandom_range(0, 4) == 0);
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      $display("%0d bytes sent (%0d while decoding), %0d code units and %0d strings checked",
               bytes_sent, live_bytes, units_seen, strings_seen);
      $display("capacity swept over %0d settings from 0 to 256 bytes, %0d mismatches",
               PHASES + 2, mismatches);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== utf8_to_utf16le_stream_unit.f =====
rtl/u8u16_pkg.sv
rtl/u8u16_chan.sv
rtl/u8u16_core.sv
rtl/u8u16_rsp_reg.sv
rtl/utf8_to_utf16le_stream_unit.sv
test/tb_utf8_to_utf16le_stream_unit.sv
